[rtl/core/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation codes, payload structs and the beat formats of both channels.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned FieldBits = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]                  opcode;
    logic signed [FieldBits-1:0] left_num;
    logic signed [FieldBits-1:0] left_den;
    logic signed [FieldBits-1:0] right_num;
    logic signed [FieldBits-1:0] right_den;
  } in_beat_t;

  typedef struct packed {
    logic signed [FieldBits-1:0] result_num;
    logic signed [FieldBits-1:0] result_den;
    logic                        is_same;
    logic                        overflowed;
    logic                        zero_gcd_error;
  } out_beat_t;

endpackage

[rtl/core/rau_divider.sv]
// ----------------------------------------------------------------------------
// rau_divider: shared unsigned restoring divider
// One quotient bit per cycle; gives quotient and remainder of two magnitudes.
// ----------------------------------------------------------------------------
module rau_divider #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo;
  logic [W:0]    rem;
  logic [W-1:0]  dsr;
  logic [CW-1:0] count;
  logic          busy;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  // one shift-subtract step
  always_comb begin
    shifted = {rem[W-1:0], quo[W-1]};
    trial   = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial;
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem[W-1:0];
endmodule

[rtl/core/rau_multiplier.sv]
// ----------------------------------------------------------------------------
// rau_multiplier: shared shift-add magnitude multiplier
// One partial product bit per cycle; full 2W-bit product of two magnitudes.
// ----------------------------------------------------------------------------
module rau_multiplier #(
  parameter int unsigned W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   mcand,
  input  logic [W-1:0]   mplier,
  output logic           done,
  output logic [2*W-1:0] product
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [2*W-1:0] acc;
  logic [W-1:0]   mc;
  logic [W-1:0]   mp;
  logic [CW-1:0]  count;
  logic           busy;
  logic [W:0]     hi_sum;

  // add multiplicand into the high half when the low multiplier bit is set
  always_comb begin
    hi_sum = {1'b0, acc[2*W-1:W]} + (mp[0] ? {1'b0, mc} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mc  <= mcand;
      mp  <= mplier;
    end else if (busy) begin
      acc <= {hi_sum, acc[W-1:1]};
      mp  <= mp >> 1;
    end
  end

  assign product = acc;
endmodule

[rtl/core/rational_arith_unit.sv]
// ----------------------------------------------------------------------------
// rational_arith_unit: fraction arithmetic with GCD reduction
// Add, subtract, multiply, divide or compare two fractions, reduced by GCD.
// ----------------------------------------------------------------------------
// Sequence: up to three products on the shared bit-serial multiplier, then Euclid
//   steps and two final divides on the shared bit-serial divider; compare runs
//   two reductions. One beat at a time: in_ready only while idle.
// Reset: rst is synchronous and active high; sequencer returns to idle.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rau_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rau_pkg::out_beat_t out_data
);
  import rau_pkg::*;

  localparam int unsigned W = WORD_BITS;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MUL1  = 12'b000000000010,
    S_MUL2  = 12'b000000000100,
    S_MUL3  = 12'b000000001000,
    S_SUM   = 12'b000000010000,
    S_RED   = 12'b000000100000,
    S_GCD   = 12'b000001000000,
    S_DIVP  = 12'b000010000000,
    S_DIVQ  = 12'b000100000000,
    S_NEXT  = 12'b001000000000,
    S_OUT   = 12'b010000000000,
    S_WAITU = 12'b100000000000
  } state_t;

  state_t state, ret_state;

  // captured operands, sign-magnitude
  logic [2:0]   op;
  logic         ln_s, ld_s, rn_s, rd_s;
  logic [W-1:0] ln_m, ld_m, rn_m, rd_m;
  // products (sign, full magnitude)
  logic         t1_s, t2_s, q_s;
  logic [2*W-1:0] t1_m, t2_m, q_m;
  // fraction under reduction
  logic         p_s, d_s;
  logic [W-1:0] p_m, d_m;
  logic [W-1:0] ga, gb;
  logic         ovf, err, second;
  logic [W-1:0] c_nm, c_dm;
  logic         c_ns, c_ds;
  out_beat_t    res;

  // shared unit hookup
  logic           m_start, m_done;
  logic [W-1:0]   m_a, m_b;
  logic [2*W-1:0] m_prod;
  logic           d_start, d_done;
  logic [W-1:0]   d_a, d_b, d_q, d_r;

  rau_multiplier #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .start(m_start), .mcand(m_a), .mplier(m_b),
    .done(m_done), .product(m_prod)
  );

  rau_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(d_start), .dividend(d_a), .divisor(d_b),
    .done(d_done), .quotient(d_q), .remainder(d_r)
  );

  function automatic logic [W-1:0] fld(input logic [FieldBits-1:0] raw);
    logic [W-1:0] v;
    begin
      if (W >= FieldBits) v = W'(signed'(raw));
      else v = W'(raw);
      return v;
    end
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // signed range check of a sign-magnitude value with a 2W+1 bit magnitude
  function automatic logic oor(input logic s, input logic [2*W:0] m);
    logic [2*W:0] lim;
    begin
      lim = (2*W+1)'(1) << (W-1);
      return s ? (m > lim) : (m >= lim);
    end
  endfunction

  // wrap to a W-bit word and re-split into sign and magnitude
  function automatic logic [W:0] wrapsm(input logic s, input logic [2*W:0] m);
    logic [W-1:0] u;
    begin
      u = s ? W'(~m + 1'b1) : m[W-1:0];
      return {u[W-1], mag(u)};
    end
  endfunction

  // input fields wrapped to the word size
  logic [W-1:0] in_ln, in_ld, in_rn, in_rd;
  assign in_ln = fld(in_data.left_num);
  assign in_ld = fld(in_data.left_den);
  assign in_rn = fld(in_data.right_num);
  assign in_rd = fld(in_data.right_den);

  // sum stage, from t1/t2
  logic [2*W:0] s_m;
  logic         s_s;
  logic [W:0]   wsum, wq, wt1, wt2;
  always_comb begin
    if (t1_s == t2_s) begin
      s_s = t1_s; s_m = {1'b0, t1_m} + {1'b0, t2_m};
    end else if (t1_m >= t2_m) begin
      s_s = t1_s; s_m = {1'b0, t1_m - t2_m};
    end else begin
      s_s = t2_s; s_m = {1'b0, t2_m - t1_m};
    end
    if (s_m == '0) s_s = 1'b0;
    wsum = wrapsm(s_s, s_m);
    wq   = wrapsm(q_s, {1'b0, q_m});
    wt1  = wrapsm(t1_s, {1'b0, t1_m});
    wt2  = wrapsm(t2_s, {1'b0, t2_m});
  end

  // unit operand selection
  always_comb begin
    m_a = ln_m; m_b = rd_m;
    case (state)
      S_MUL1: begin m_a = ln_m; m_b = (op == OP_MUL) ? rn_m : rd_m; end
      S_MUL2: begin m_a = (op == OP_ADD || op == OP_SUB) ? rn_m : ld_m;
                    m_b = (op == OP_MUL) ? rd_m : (op == OP_DIV) ? rn_m : ld_m; end
      S_MUL3: begin m_a = ld_m; m_b = rd_m; end
      default: ;
    endcase
    d_a = ga; d_b = gb;
    case (state)
      S_DIVP: begin d_a = p_m; d_b = ga; end
      S_DIVQ: begin d_a = d_m; d_b = ga; end
      default: ;
    endcase
  end

  logic busy_unit;
  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign out_data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      out_valid <= 1'b0;
      m_start   <= 1'b0;
      d_start   <= 1'b0;
      busy_unit <= 1'b0;
    end else begin
      m_start <= 1'b0;
      d_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op   <= in_data.opcode;
            ln_s <= in_ln[W-1]; ln_m <= mag(in_ln);
            ld_s <= in_ld[W-1]; ld_m <= mag(in_ld);
            rn_s <= in_rn[W-1]; rn_m <= mag(in_rn);
            rd_s <= in_rd[W-1]; rd_m <= mag(in_rd);
            ovf <= 1'b0; err <= 1'b0; second <= 1'b0;
            res <= '0;
            if (in_data.opcode <= 3'(OP_DIV)) begin
              state <= S_MUL1; m_start <= 1'b1; busy_unit <= 1'b0;
            end else if (in_data.opcode == 3'(OP_CMP)) begin
              state <= S_RED; busy_unit <= 1'b0;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_MUL1: if (m_done) begin
          t1_m <= m_prod;
          t1_s <= (m_prod != '0) &&
                  (ln_s != ((op == OP_MUL) ? rn_s : rd_s));
          state <= S_MUL2; m_start <= 1'b1;
        end
        S_MUL2: if (m_done) begin
          t2_m <= m_prod;
          if (op == OP_DIV)
            t2_s <= (m_prod != '0) && (ld_s != rn_s);
          else if (op == OP_MUL)
            t2_s <= (m_prod != '0) && (ld_s != rd_s);
          else
            t2_s <= (m_prod != '0) && ((rn_s != ld_s) != (op == OP_SUB));
          if (op == OP_MUL || op == OP_DIV) begin
            state <= S_SUM;
          end else begin
            state <= S_MUL3; m_start <= 1'b1;
          end
        end
        S_MUL3: if (m_done) begin
          q_m <= m_prod;
          q_s <= (m_prod != '0) && (ld_s != rd_s);
          state <= S_SUM;
        end
        S_SUM: begin
          if (op == OP_MUL || op == OP_DIV) begin
            ovf <= oor(t1_s, {1'b0, t1_m}) || oor(t2_s, {1'b0, t2_m});
            p_s <= wt1[W];
            p_m <= wt1[W-1:0];
            d_s <= wt2[W];
            d_m <= wt2[W-1:0];
          end else begin
            ovf <= oor(t1_s, {1'b0, t1_m}) || oor(t2_s, {1'b0, t2_m}) ||
                   oor(s_s, s_m) || oor(q_s, {1'b0, q_m});
            p_s <= wsum[W]; p_m <= wsum[W-1:0];
            d_s <= wq[W];   d_m <= wq[W-1:0];
          end
          state <= S_RED;
        end
        S_RED: begin
          // load the fraction to reduce and start Euclid
          if (op == OP_CMP) begin
            if (!second) begin
              p_s <= ln_s; p_m <= ln_m; d_s <= ld_s; d_m <= ld_m;
              ga <= ln_m; gb <= ld_m;
            end else begin
              p_s <= rn_s; p_m <= rn_m; d_s <= rd_s; d_m <= rd_m;
              ga <= rn_m; gb <= rd_m;
            end
          end else begin
            ga <= p_m; gb <= d_m;
          end
          state <= S_GCD;
        end
        S_GCD: begin
          if (!busy_unit) begin
            if (gb == '0) begin
              if (ga == '0) begin
                err <= 1'b1; state <= S_NEXT;
              end else begin
                state <= S_DIVP; d_start <= 1'b1; busy_unit <= 1'b1;
              end
            end else begin
              d_start <= 1'b1; busy_unit <= 1'b1;
            end
          end else if (d_done) begin
            ga <= gb; gb <= d_r; busy_unit <= 1'b0;
          end
        end
        S_DIVP: if (d_done) begin
          p_m <= d_q; state <= S_DIVQ; d_start <= 1'b1;
        end
        S_DIVQ: if (d_done) begin
          d_m <= d_q; busy_unit <= 1'b0; state <= S_NEXT;
        end
        S_NEXT: begin
          if (op == OP_CMP && !second) begin
            c_ns <= p_s; c_nm <= p_m; c_ds <= d_s; c_dm <= d_m;
            second <= 1'b1; state <= S_RED;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          res.overflowed     <= ovf;
          res.zero_gcd_error <= err;
          if (op == OP_CMP) begin
            res.is_same <= !err && (c_ns == p_s) && (c_nm == p_m) &&
                           (c_ds == d_s) && (c_dm == d_m);
          end else if (op <= 3'(OP_DIV) && !err) begin
            res.result_num <= FieldBits'(signed'(p_s ? (~p_m + 1'b1) : p_m));
            res.result_den <= FieldBits'(signed'(d_s ? (~d_m + 1'b1) : d_m));
          end
          out_valid <= 1'b1;
          state     <= S_WAITU;
        end
        S_WAITU: begin
          ret_state <= S_IDLE;
          state     <= ret_state;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/rau_checker.sv]
// ----------------------------------------------------------------------------
// rau_checker: port-level checks for the rational arithmetic unit
// Watches handshakes and result flags at the top level ports.
// ----------------------------------------------------------------------------
module rau_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rau_pkg::out_beat_t out_data
);
  import rau_pkg::*;

  // a result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // no new input while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken with result pending");

  // an input beat never produces a result on the next edge
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_gcd_error |->
      out_data.result_num == '0 && out_data.result_den == '0 && !out_data.is_same)
    else $error("error result not zero");
endmodule

bind rational_arith_unit rau_checker u_rau_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
